// ----- design/gtr_pkg.sv -----
// Shared constants and types for the geocentric/topocentric rotation block.
// No dependencies; compiled first.
package gtr_pkg;

  // trig registers are fixed-width Q2.x words
  localparam int TRIG_W     = 32;
  // partial product chunk width of the wide multipliers
  localparam int CHUNK_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int LANES      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIN_LON  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_LON  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_LAT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_LAT  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 8'd7;

  // reset value of the cosine registers (1.0 in Q2.30; cos_lat is unsigned Q1.30)
  localparam logic signed [TRIG_W-1:0] COS_LON_RST = 32'sd1073741824;
  localparam logic [TRIG_W-2:0]        COS_LAT_RST = 31'd1073741824;

  typedef struct packed {
    logic clamp_hi;
    logic clamp_lo;
  } lane_flags_t;

endpackage

// ----- design/gtr_if.sv -----
// Channel interfaces: point request, result request and configuration write.
// Depends on gtr_pkg.
interface gtr_pt_if #(parameter int W = 40) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coord_a;
  logic signed [W-1:0] coord_b;
  logic signed [W-1:0] coord_c;

  modport source (output valid, output coord_a, output coord_b, output coord_c, input ready);
  modport sink   (input valid, input coord_a, input coord_b, input coord_c, output ready);
endinterface

interface gtr_res_if #(parameter int W = 40) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_a;
  logic signed [W-1:0] out_b;
  logic signed [W-1:0] out_c;
  logic                saturated;

  modport source (output valid, output out_a, output out_b, output out_c,
                  output saturated, input ready);
  modport sink   (input valid, input out_a, input out_b, input out_c,
                  input saturated, output ready);
endinterface

interface gtr_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [gtr_pkg::CFG_IDX_W-1:0]  index;
  logic [gtr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/gtr_mul.sv -----
// Pipelined signed multiplier built from 33x33 chunk products.
// Depends on gtr_pkg.
module gtr_mul #(
  parameter int AW = 64,
  parameter int BW = 41
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import gtr_pkg::*;

  localparam int PW  = AW + BW;
  localparam int NA  = (AW + CHUNK_W - 1) / CHUNK_W;
  localparam int NB  = (BW + CHUNK_W - 1) / CHUNK_W;
  localparam int AEW = NA * CHUNK_W;
  localparam int BEW = NB * CHUNK_W;

  logic signed [AEW-1:0]       a_ext;
  logic signed [BEW-1:0]       b_ext;
  logic signed [CHUNK_W:0]     ac [NA];
  logic signed [CHUNK_W:0]     bc [NB];
  logic signed [2*CHUNK_W+1:0] pp [NA][NB];
  logic [PW-1:0]               row_next [NA];
  logic [PW-1:0]               row [NA];
  logic [PW-1:0]               p_next;

  assign a_ext = AEW'(a);
  assign b_ext = BEW'(b);

  // lower chunks are unsigned, the top chunk carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_achunk
    if (i == NA - 1) begin : g_top
      assign ac[i] = {a_ext[CHUNK_W*i+CHUNK_W-1], a_ext[CHUNK_W*i +: CHUNK_W]};
    end else begin : g_low
      assign ac[i] = {1'b0, a_ext[CHUNK_W*i +: CHUNK_W]};
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bchunk
    if (j == NB - 1) begin : g_top
      assign bc[j] = {b_ext[CHUNK_W*j+CHUNK_W-1], b_ext[CHUNK_W*j +: CHUNK_W]};
    end else begin : g_low
      assign bc[j] = {1'b0, b_ext[CHUNK_W*j +: CHUNK_W]};
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_pp_row
    for (genvar j = 0; j < NB; j++) begin : g_pp_col
      always_ff @(posedge clk) begin
        if (adv) begin
          pp[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  // sums wrap modulo 2^PW; the full product always fits in PW bits
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (CHUNK_W * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row <= row_next;
    end
  end

  always_comb begin
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (row[i] << (CHUNK_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p <= $signed(p_next);
    end
  end

endmodule

// ----- design/gtr_lane.sv -----
// One output lane: three-term dot product, origin add (inverse mode only), rounding and clamp.
// Depends on gtr_pkg and gtr_mul.
module gtr_lane #(
  parameter int COORD_WIDTH    = 40,
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic signed [((gtr_pkg::TRIG_W + 1 + TRIG_FRAC_BITS > 2 * gtr_pkg::TRIG_W) ?
                        gtr_pkg::TRIG_W + 1 + TRIG_FRAC_BITS : 2 * gtr_pkg::TRIG_W)-1:0]
                                         coef [3],
  input  logic signed [COORD_WIDTH:0]    d [3],
  input  logic signed [COORD_WIDTH-1:0]  origin,
  input  logic                           inverse_mode,
  output logic signed [COORD_WIDTH-1:0]  value,
  output gtr_pkg::lane_flags_t           flags
);
  import gtr_pkg::*;

  localparam int F    = TRIG_FRAC_BITS;
  localparam int CW   = COORD_WIDTH;
  localparam int MW   = (TRIG_W + 1 + F > 2 * TRIG_W) ? TRIG_W + 1 + F : 2 * TRIG_W;
  localparam int DW   = CW + 1;
  localparam int PW   = MW + DW;
  localparam int SUMW = (PW > CW + 2 * F) ? PW : CW + 2 * F;
  localparam int ACCW = SUMW + 3;
  localparam logic signed [ACCW-1:0] HALF    = ACCW'(1) << (2 * F - 1);
  localparam logic signed [CW-1:0]   OUT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]   OUT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [PW-1:0]   prod [3];
  logic signed [ACCW-1:0] org_term;
  logic signed [ACCW-1:0] acc_next;
  logic signed [ACCW-1:0] acc;
  logic [ACCW-2*F-CW:0]   upper;
  logic                   fits;

  for (genvar k = 0; k < 3; k++) begin : g_mul
    gtr_mul #(.AW(MW), .BW(DW)) u_mul (
      .clk (clk),
      .adv (adv),
      .a   (coef[k]),
      .b   (d[k]),
      .p   (prod[k])
    );
  end

  // inverse mode adds the origin, scaled to Q(2F), into the same sum
  assign org_term = inverse_mode ? (ACCW'(origin) <<< (2 * F)) : '0;
  assign acc_next = ACCW'(prod[0]) + ACCW'(prod[1]) + ACCW'(prod[2]) + org_term + HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= acc_next;
    end
  end

  // result fits when the output sign bit and all bits above it agree
  assign upper = acc[ACCW-1 : 2*F+CW-1];
  assign fits  = (&upper) | ~(|upper);

  always_comb begin
    flags.clamp_hi = ~fits & ~acc[ACCW-1];
    flags.clamp_lo = ~fits & acc[ACCW-1];
    if (fits) begin
      value = acc[2*F +: CW];
    end else if (acc[ACCW-1]) begin
      value = OUT_MIN;
    end else begin
      value = OUT_MAX;
    end
  end

endmodule

// ----- design/gtr_merge.sv -----
// Merge stage: collects the three lane results into the output register.
// Depends on gtr_pkg and gtr_if.
module gtr_merge #(
  parameter int COORD_WIDTH = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vld_in,
  input  logic signed [COORD_WIDTH-1:0] value [3],
  input  gtr_pkg::lane_flags_t          flags [3],
  output logic                          adv,
  gtr_res_if.source                     res
);
  import gtr_pkg::*;

  logic any_clamp;

  // pipeline moves whenever the output register is free or being emptied
  assign adv = ~res.valid | res.ready;

  always_comb begin
    any_clamp = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      any_clamp = any_clamp | flags[i].clamp_hi | flags[i].clamp_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_in) begin
      res.out_a     <= value[0];
      res.out_b     <= value[1];
      res.out_c     <= value[2];
      res.saturated <= any_clamp;
    end
  end

endmodule

// ----- design/geocentric_topocentric_rotation.sv -----
// Geocentric <-> topocentric (ENU) rotation, one point per cycle.
// Datapath registers from accept to result: input, 3 multiplier, sum and output.
// Throughput: one point per cycle unless the output stalls; all stages are pipelined and advance together.
// Output stalls hold the whole pipeline; ready is low only while the output is held or in reset.
// Synchronous reset empties the pipeline and resets the config registers; datapath is not reset.
// Depends on gtr_pkg, gtr_if, gtr_mul, gtr_lane and gtr_merge.
module geocentric_topocentric_rotation #(
  parameter int COORD_WIDTH    = 40,
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic       clk,
  input  logic       rst,
  gtr_cfg_if.sink    cfg,
  gtr_pt_if.sink     pt_in,
  gtr_res_if.source  res_out
);
  import gtr_pkg::*;

  localparam int F  = TRIG_FRAC_BITS;
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int MW = (TRIG_W + 1 + F > 2 * TRIG_W) ? TRIG_W + 1 + F : 2 * TRIG_W;
  localparam int DEPTH = 6;

  logic signed [TRIG_W-1:0]   sin_lon;
  logic signed [TRIG_W-1:0]   cos_lon;
  logic signed [TRIG_W-1:0]   sin_lat;
  logic [TRIG_W-2:0]          cos_lat;
  logic signed [CW-1:0]       origin [3];
  logic                       inverse_mode;

  logic signed [TRIG_W-1:0]   cos_lat_s;
  logic signed [2*TRIG_W-1:0] p_spcl;
  logic signed [2*TRIG_W-1:0] p_spsl;
  logic signed [2*TRIG_W-1:0] p_cpcl;
  logic signed [2*TRIG_W-1:0] p_cpsl;
  logic signed [MW-1:0]       rot [3][3];
  logic signed [MW-1:0]       coef [3][3];

  logic signed [CW-1:0]       pt [3];
  logic signed [DW-1:0]       d_next [3];
  logic signed [DW-1:0]       d [3];
  logic [DEPTH-2:0]           vld;
  logic                       adv;
  logic                       accept;

  logic signed [CW-1:0]       value [3];
  lane_flags_t                flags [3];

  // configuration writes; indexes past the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_lon      <= '0;
      cos_lon      <= COS_LON_RST;
      sin_lat      <= '0;
      cos_lat      <= COS_LAT_RST;
      origin[0]    <= '0;
      origin[1]    <= '0;
      origin[2]    <= '0;
      inverse_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SIN_LON:  sin_lon      <= cfg.data[TRIG_W-1:0];
        REG_COS_LON:  cos_lon      <= cfg.data[TRIG_W-1:0];
        REG_SIN_LAT:  sin_lat      <= cfg.data[TRIG_W-1:0];
        REG_COS_LAT:  cos_lat      <= cfg.data[TRIG_W-2:0];
        REG_ORIGIN_X: origin[0]    <= cfg.data[CW-1:0];
        REG_ORIGIN_Y: origin[1]    <= cfg.data[CW-1:0];
        REG_ORIGIN_Z: origin[2]    <= cfg.data[CW-1:0];
        REG_INVERSE:  inverse_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // rotation matrix, all entries in Q(2F)
  assign cos_lat_s = $signed({1'b0, cos_lat});
  assign p_spcl    = sin_lat * cos_lon;
  assign p_spsl    = sin_lat * sin_lon;
  assign p_cpcl    = cos_lat_s * cos_lon;
  assign p_cpsl    = cos_lat_s * sin_lon;

  always_comb begin
    rot[0][0] = -(MW'(sin_lon) <<< F);
    rot[0][1] = -MW'(p_spcl);
    rot[0][2] = MW'(p_cpcl);
    rot[1][0] = MW'(cos_lon) <<< F;
    rot[1][1] = -MW'(p_spsl);
    rot[1][2] = MW'(p_cpsl);
    rot[2][0] = '0;
    rot[2][1] = MW'(cos_lat_s) <<< F;
    rot[2][2] = MW'(sin_lat) <<< F;
  end

  // lane i takes column i going forward, row i going back
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef[i][k] <= inverse_mode ? rot[i][k] : rot[k][i];
      end
    end
  end

  // input stage: coordinate difference (forward mode) kept at full width
  assign accept      = pt_in.valid & pt_in.ready;
  assign pt_in.ready = adv & ~rst;
  assign pt[0]       = pt_in.coord_a;
  assign pt[1]       = pt_in.coord_b;
  assign pt[2]       = pt_in.coord_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_next[k] = inverse_mode ? DW'(pt[k]) : DW'(pt[k]) - DW'(origin[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d <= d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-3:0], accept};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    gtr_lane #(
      .COORD_WIDTH    (CW),
      .TRIG_FRAC_BITS (F)
    ) u_lane (
      .clk          (clk),
      .adv          (adv),
      .coef         (coef[i]),
      .d            (d),
      .origin       (origin[i]),
      .inverse_mode (inverse_mode),
      .value        (value[i]),
      .flags        (flags[i])
    );
  end

  gtr_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk    (clk),
    .rst    (rst),
    .vld_in (vld[DEPTH-2]),
    .value  (value),
    .flags  (flags),
    .adv    (adv),
    .res    (res_out)
  );

  // an accepted request reaches the output if the pipeline keeps advancing
  assert property (@(posedge clk) disable iff (rst)
    accept ##1 adv ##1 adv ##1 adv ##1 adv ##1 adv |=> res_out.valid)
    else $error("accepted request did not reach the output");

  // a held output blocks new requests
  assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |-> !pt_in.ready)
    else $error("request accepted while output held");

  // reset leaves the pipeline empty
  assert property (@(posedge clk)
    $past(rst) |-> !res_out.valid && (vld == '0))
    else $error("pipeline not empty after reset");

endmodule
